// File: design/key_value_multimap_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key/value multimap table
// Concurrent property wrappers sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_MULTIMAP_TABLE_DEFINES_SVH
`define KEY_VALUE_MULTIMAP_TABLE_DEFINES_SVH

// same-cycle implication
`define KVM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kvm_pkg.sv
// ----------------------------------------------------------------------------
// kvm_pkg
// Operation and status codes, field widths and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package kvm_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic [VAL_W-1:0]   found_value;
        logic               last;
        logic [COUNT_W-1:0] pair_count;
        logic               is_empty;
    } kvm_result_t;

endpackage

`default_nettype wire

// File: design/kvm_ram.sv
// ----------------------------------------------------------------------------
// kvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/kvm_out_stage.sv
// ----------------------------------------------------------------------------
// kvm_out_stage
// Result register holding one beat for the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module kvm_out_stage
    import kvm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire kvm_result_t push_data,
    output logic             slot_free,
    output logic             out_valid,
    input  wire logic        out_ready,
    output kvm_result_t      out_data
);

    logic        valid_reg;
    logic        valid_next;
    kvm_result_t data_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/key_value_multimap_table.sv
// Add and unused codes go from acceptance straight to the response state.
// Remove scans newest to oldest, one stored pair a cycle, then shifts the
// younger pairs down one slot a cycle. Search scans one pair a cycle, stalling
// on back-pressure. One item at a time through the single RAM port pair; ready
// again after the final beat is registered. Reset clears state, pair count and
// pending hit flag; no RAM sweep.
// ----------------------------------------------------------------------------
// key_value_multimap_table
// Bounded multimap of key/value pairs kept oldest to newest in one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_multimap_table
    import kvm_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // found_value[31:0], pair_count[38:32], is_empty[39]
    output logic      [1:0]  m_tuser,   // status[1:0]
    output logic             m_tlast
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    scan_reg, scan_next;
    logic [AW-1:0]    shift_reg, shift_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [VAL_W-1:0] pend_value_reg, pend_value_next;
    logic [1:0]       resp_status_reg, resp_status_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [KEY_W+VAL_W-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [KEY_W+VAL_W-1:0] ram_rdata;

    logic             push;
    kvm_result_t      push_data;
    logic             slot_free;
    kvm_result_t      out_data;

    logic [AW-1:0]    last_idx;
    logic             full;
    logic             key_hit;
    logic             pair_hit;

    assign last_idx = count_reg[AW-1:0] - 1'b1;
    assign full     = (count_reg == CW'(ENTRIES));
    assign key_hit  = (ram_rdata[KEY_W-1:0] == key_reg);
    assign pair_hit = key_hit && (ram_rdata[KEY_W+VAL_W-1:KEY_W] == value_reg);
    assign s_tready = (state_reg == ST_IDLE);

    kvm_ram #(
        .WIDTH (KEY_W + VAL_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kvm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .slot_free (slot_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.is_empty, out_data.pair_count, out_data.found_value};
    assign m_tuser = out_data.status;
    assign m_tlast = out_data.last;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        count_next       = count_reg;
        scan_next        = scan_reg;
        shift_next       = shift_reg;
        pend_valid_next  = pend_valid_reg;
        pend_value_next  = pend_value_reg;
        resp_status_next = resp_status_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = s_tdata;
        ram_raddr = scan_reg;

        push                  = 1'b0;
        push_data.status      = STATUS_DONE;
        push_data.found_value = pend_value_reg;
        push_data.last        = 1'b0;
        push_data.pair_count  = COUNT_W'(count_reg);
        push_data.is_empty    = (count_reg == '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next          = s_tuser;
                    key_next         = s_tdata[KEY_W-1:0];
                    value_next       = s_tdata[KEY_W+VAL_W-1:KEY_W];
                    pend_valid_next  = 1'b0;
                    resp_status_next = STATUS_NOT_FOUND;
                    state_next       = ST_RESP;
                    case (s_tuser)
                        OP_ADD:
                        begin
                            if (full)
                            begin
                                resp_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                count_next       = count_reg + 1'b1;
                                resp_status_next = STATUS_DONE;
                            end
                        end
                        OP_REMOVE, OP_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_raddr  = last_idx;
                                scan_next  = last_idx;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (op_reg == OP_REMOVE)
                begin
                    if (pair_hit)
                    begin
                        count_next       = count_reg - 1'b1;
                        resp_status_next = STATUS_DONE;
                        if (scan_reg == last_idx)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            ram_raddr  = scan_reg + 1'b1;
                            shift_next = scan_reg;
                            state_next = ST_SHIFT;
                        end
                    end
                    else if (scan_reg == '0)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ram_raddr = scan_reg - 1'b1;
                        scan_next = scan_reg - 1'b1;
                    end
                end
                else
                begin
                    // newer hit, seen first, waits in the pending register until the next one is seen
                    if (key_hit && pend_valid_reg && !slot_free)
                    begin
                        ram_raddr = scan_reg;
                    end
                    else
                    begin
                        if (key_hit)
                        begin
                            push            = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_value_next = ram_rdata[KEY_W+VAL_W-1:KEY_W];
                        end
                        if (scan_reg == '0)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            ram_raddr = scan_reg - 1'b1;
                            scan_next = scan_reg - 1'b1;
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = shift_reg;
                ram_wdata  = ram_rdata;
                ram_raddr  = shift_reg + AW'(2);
                shift_next = shift_reg + 1'b1;
                if (shift_reg == last_idx)
                begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                push_data.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    push_data.status      = resp_status_reg;
                    push_data.found_value = '0;
                end
                if (slot_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        value_reg       <= value_next;
        scan_reg        <= scan_next;
        shift_reg       <= shift_next;
        pend_value_reg  <= pend_value_next;
        resp_status_reg <= resp_status_next;
    end

endmodule

`default_nettype wire

// File: design/kvm_checker.sv
// ----------------------------------------------------------------------------
// kvm_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_value_multimap_table_defines.svh"

module kvm_checker
    import kvm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    `KVM_ASSERT_NXT(a_beat_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")
    `KVM_ASSERT_IMP(a_miss_last, m_tvalid && (m_tuser != STATUS_DONE), m_tlast && (m_tdata[31:0] == 32'd0), "miss or full beat not final or value not zero")
    `KVM_ASSERT_IMP(a_mid_hit, m_tvalid && !m_tlast, m_tuser == STATUS_DONE && !m_tdata[39], "non-final beat is not a search hit")
    `KVM_ASSERT_IMP(a_empty_flag, m_tvalid, m_tdata[39] == (m_tdata[38:32] == 7'd0), "empty flag disagrees with pair count")

endmodule

bind key_value_multimap_table kvm_checker u_kvm_checker (.*);

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: key/value multimap table testbench
// A table of directed steps, typed in where the outcome is plain, then random
// add/remove/search traffic. Typed-in beats are checked as typed, the rest against
// a shadow copy of the table. Idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import kvm_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int RANDOM_ITEMS = 318;
    localparam int HOLD_AT      = 340;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [31:0] KEY_POOL [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h5A5A_5A5A, 32'h1234_5678, 32'hDEAD_BEEF
    };

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] val;
        int          reps;
        bit          fixed;
        logic [1:0]  status;
        logic [6:0]  count;
    } plan_row_t;

    localparam int PLAN_LEN = 24;

    plan_row_t plan [PLAN_LEN] = '{
        '{OP_SEARCH, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, STATUS_NOT_FOUND, 7'd0},
        '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, STATUS_NOT_FOUND, 7'd0},
        '{OP_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, STATUS_NOT_FOUND, 7'd0},
        '{OP_ADD,    32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b1, STATUS_DONE,      7'd1},
        '{OP_ADD,    32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b1, STATUS_DONE,      7'd2},
        '{OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, STATUS_DONE,      7'd3},
        '{OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, STATUS_DONE,      7'd4},
        '{OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, STATUS_DONE,      7'd5},
        '{OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0, STATUS_DONE,      7'd0},
        '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, STATUS_DONE,      7'd4},
        '{OP_SEARCH, 32'hFFFF_FFFF, 32'h1234_5678, 1, 1'b0, STATUS_DONE,      7'd0},
        '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0005, 1, 1'b1, STATUS_NOT_FOUND, 7'd4},
        '{OP_REMOVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1'b1, STATUS_NOT_FOUND, 7'd4},
        '{OP_SEARCH, 32'h8000_0000, 32'h0000_0000, 1, 1'b0, STATUS_DONE,      7'd0},
        '{OP_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, STATUS_NOT_FOUND, 7'd4},
        // fill to the brim, then bounce off it
        '{OP_ADD,    32'h5A5A_5A5A, 32'hA5A5_A5A5, 60, 1'b0, STATUS_DONE,     7'd0},
        '{OP_ADD,    32'h0000_0000, 32'h0000_0000, 1, 1'b1, STATUS_FULL,      7'd64},
        '{OP_SPARE,  32'h0000_0000, 32'h0000_0000, 1, 1'b1, STATUS_NOT_FOUND, 7'd64},
        '{OP_SEARCH, 32'h5A5A_5A5A, 32'h0000_0000, 1, 1'b0, STATUS_DONE,      7'd0},
        '{OP_REMOVE, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b1, STATUS_DONE,      7'd63},
        '{OP_ADD,    32'h0000_0000, 32'h0000_0000, 1, 1'b1, STATUS_DONE,      7'd64},
        '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, STATUS_DONE,      7'd63},
        '{OP_REMOVE, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 60, 1'b0, STATUS_DONE,     7'd0},
        '{OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0, STATUS_DONE,      7'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key[31:0], value[63:32]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // found_value[31:0], pair_count[38:32], is_empty[39]
    logic [1:0]  m_tuser;   // status[1:0]
    logic        m_tlast;

    key_value_multimap_table #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // shadow copy of the table, oldest pair in slot 0
    logic [31:0] shadow_key [ENTRIES];
    logic [31:0] shadow_val [ENTRIES];
    int          shadow_count;

    kvm_result_t step_beats [$];
    kvm_result_t awaited_beats [$];

    bit          pend_fixed;
    kvm_result_t pend_beat;
    bit          steady;
    int          items_in;
    int          mismatches;
    int          cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic kvm_result_t make_beat(input logic [1:0] status,
                                              input logic [31:0] value, input logic last);
        kvm_result_t b;
        b.status      = status;
        b.found_value = value;
        b.last        = last;
        b.pair_count  = 7'(shadow_count);
        b.is_empty    = (shadow_count == 0);
        return b;
    endfunction

    function automatic void note_beat(input kvm_result_t b);
        step_beats.insert(step_beats.size(), b);
    endfunction

    task automatic apply_to_shadow(input logic [1:0] op, input logic [31:0] key,
                                   input logic [31:0] val);
        int hit;
        int i;
        step_beats.delete();
        hit = -1;
        case (op)
            OP_ADD:
            begin
                if (shadow_count == ENTRIES)
                    note_beat(make_beat(STATUS_FULL, '0, 1'b1));
                else
                begin
                    shadow_key[shadow_count] = key;
                    shadow_val[shadow_count] = val;
                    shadow_count++;
                    note_beat(make_beat(STATUS_DONE, '0, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                for (i = shadow_count - 1; i >= 0 && hit < 0; i--)
                    if (shadow_key[i] == key && shadow_val[i] == val)
                        hit = i;
                if (hit < 0)
                    note_beat(make_beat(STATUS_NOT_FOUND, '0, 1'b1));
                else
                begin
                    for (i = hit; i + 1 < shadow_count; i++)
                    begin
                        shadow_key[i] = shadow_key[i + 1];
                        shadow_val[i] = shadow_val[i + 1];
                    end
                    shadow_count--;
                    note_beat(make_beat(STATUS_DONE, '0, 1'b1));
                end
            end
            OP_SEARCH:
            begin
                for (i = shadow_count - 1; i >= 0; i--)
                    if (shadow_key[i] == key)
                        note_beat(make_beat(STATUS_DONE, shadow_val[i], 1'b0));
                if (step_beats.size() == 0)
                    note_beat(make_beat(STATUS_NOT_FOUND, '0, 1'b1));
                else
                    step_beats[step_beats.size() - 1].last = 1'b1;
            end
            default:
                note_beat(make_beat(STATUS_NOT_FOUND, '0, 1'b1));
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        kvm_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat status %0d value %h last %b",
                             $time, m_tuser, m_tdata[31:0], m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = awaited_beats.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_tuser));
                    compare_field("found_value", want.found_value, m_tdata[31:0]);
                    compare_field("last", 32'(want.last), 32'(m_tlast));
                    compare_field("pair_count", 32'(want.pair_count), 32'(m_tdata[38:32]));
                    compare_field("is_empty", 32'(want.is_empty), 32'(m_tdata[39]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_to_shadow(s_tuser, s_tdata[31:0], s_tdata[63:32]);
                if (pend_fixed)
                    awaited_beats.insert(awaited_beats.size(), pend_beat);
                else
                    foreach (step_beats[j])
                        awaited_beats.insert(awaited_beats.size(), step_beats[j]);
                items_in++;
            end
        end
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_item(input logic [1:0] op, input logic [31:0] key,
                             input logic [31:0] val, input bit fixed,
                             input kvm_result_t fixed_beat);
        while (!steady && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= {val, key};
        pend_fixed = fixed;
        pend_beat  = fixed_beat;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    initial
    begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && items_in >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        kvm_result_t fixed_beat;
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] val;
        int          roll;
        int          mode;
        int          add_pct;
        int          rem_pct;
        int          pick;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        shadow_count = 0;
        items_in     = 0;
        mismatches   = 0;
        steady       = 1'b0;
        pend_fixed   = 1'b0;
        pend_beat    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++)
        begin
            fixed_beat.status      = plan[r].status;
            fixed_beat.found_value = '0;
            fixed_beat.last        = 1'b1;
            fixed_beat.pair_count  = plan[r].count;
            fixed_beat.is_empty    = (plan[r].count == 0);
            for (int k = 0; k < plan[r].reps; k++)
                send_item(plan[r].op, plan[r].key, plan[r].val, plan[r].fixed, fixed_beat);
        end

        // phases alternate between balanced, filling and draining traffic
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady  = (n >= 150 && n < 260);
            mode    = (n / 80) % 3;
            add_pct = (mode == 1) ? 85 : (mode == 2) ? 15 : 40;
            rem_pct = (mode == 1) ? 5 : (mode == 2) ? 55 : 30;
            roll    = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_SPARE;
            else if (roll < 3 + add_pct)
                op = OP_ADD;
            else if (roll < 3 + add_pct + rem_pct)
                op = OP_REMOVE;
            else
                op = OP_SEARCH;
            key = ($urandom_range(0, 4) == 0) ? $urandom() : KEY_POOL[$urandom_range(0, 7)];
            val = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom();
            if (op == OP_REMOVE && shadow_count > 0 && $urandom_range(0, 9) < 7)
            begin
                pick = $urandom_range(0, shadow_count - 1);
                key  = shadow_key[pick];
                val  = shadow_val[pick];
            end
            send_item(op, key, val, 1'b0, '0);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
